/* hdl/pbr_pkg.sv */
// ----------------------------------------------------------------------------
// pbr_pkg: shared definitions for the polynomial bisection root finder
// Widths, limits, register indexes, status codes and the request/response
// structs between the sequencer and the Horner evaluator.
// ----------------------------------------------------------------------------
package pbr_pkg;

  // Polynomial and iteration limits.
  localparam int MAX_DEGREE = 6;
  localparam int MAX_ITER   = 32;

  // Field and datapath widths.
  localparam int NUM_COEF  = 7;
  localparam int COEF_W    = 16;
  localparam int TOL_W     = 16;
  localparam int X_W       = 24;
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 16;
  localparam int IDX_W     = 3;
  localparam int ITER_W    = 6;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_A_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + X_W;

  // Tolerance after reset (0.001 in Q16).
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_0    = 3'd0,
    REG_COEF_1    = 3'd1,
    REG_COEF_2    = 3'd2,
    REG_COEF_3    = 3'd3,
    REG_COEF_4    = 3'd4,
    REG_COEF_5    = 3'd5,
    REG_COEF_6    = 3'd6,
    REG_TOLERANCE = 3'd7
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_NO_SIGN   = 2'd1,
    STAT_ITER_CAP  = 2'd2
  } status_e;

  // Coefficient set, entry i is the coefficient of x^i.
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  // Evaluation request from the sequencer.
  typedef struct packed {
    logic                  start;
    logic signed [X_W-1:0] x;
  } horner_req_t;

  // Evaluation response back to the sequencer.
  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] value;
  } horner_rsp_t;

endpackage

/* hdl/pbr_horner.sv */
// ----------------------------------------------------------------------------
// pbr_horner: iterative Horner evaluator
// Evaluates p(x) in a saturating Q47.16 accumulator. Each Horner step passes
// through five states around one shared 32x24 multiplier: magnitude, low partial
// product, high partial product, scale and saturate, add coefficient.
// ----------------------------------------------------------------------------
module pbr_horner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbr_pkg::coef_arr_t  coef_i,
  input  pbr_pkg::horner_req_t req_i,
  output pbr_pkg::horner_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCALE,
    ST_ADD
  } state_e;

  localparam logic signed [pbr_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(pbr_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [pbr_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(pbr_pkg::ACC_W-1){1'b0}}};

  state_e                                state_q;
  logic signed [pbr_pkg::ACC_W-1:0]      acc_q;
  logic        [pbr_pkg::ACC_W-1:0]      am_q;
  logic                                  neg_q;
  logic        [pbr_pkg::X_W-1:0]        xm_q;
  logic                                  xneg_q;
  logic        [pbr_pkg::IDX_W-1:0]      idx_q;
  logic        [pbr_pkg::MUL_P_W-1:0]    lo_q;
  logic        [pbr_pkg::MUL_P_W-1:0]    hi_q;
  logic signed [pbr_pkg::ACC_W-1:0]      prod_q;
  logic                                  done_q;

  logic        [pbr_pkg::MUL_A_W-1:0]    mul_a;
  logic        [pbr_pkg::MUL_P_W-1:0]    mul_p;
  logic                                  hi_big;
  logic        [pbr_pkg::ACC_W-1:0]      m_sum;
  logic        [pbr_pkg::ACC_W-1:0]      m_mag;
  logic signed [pbr_pkg::ACC_W-1:0]      prod_d;
  logic signed [pbr_pkg::ACC_W-1:0]      coef_ext;
  logic signed [pbr_pkg::ACC_W:0]        sum_wide;
  logic signed [pbr_pkg::ACC_W-1:0]      acc_d;
  logic signed [pbr_pkg::ACC_W-1:0]      lead_ext;
  logic        [pbr_pkg::X_W-1:0]        x_mag;

  // Shared multiplier: low word of the magnitude first, then the high word.
  always_comb begin
    mul_a = (state_q == ST_MUL_LO) ? am_q[pbr_pkg::MUL_A_W-1:0]
                                   : am_q[pbr_pkg::ACC_W-1:pbr_pkg::MUL_A_W];
    mul_p = mul_a * xm_q;
  end

  // Recombine the partial products, drop 16 fraction bits and apply the sign
  // with saturation to the signed 64-bit range.
  always_comb begin
    hi_big = |hi_q[pbr_pkg::MUL_P_W-1:47];
    m_sum  = {1'b0, hi_q[46:0], {pbr_pkg::FRAC_W{1'b0}}}
           + {24'd0, lo_q[pbr_pkg::MUL_P_W-1:pbr_pkg::FRAC_W]};
    m_mag  = hi_big ? {pbr_pkg::ACC_W{1'b1}} : m_sum;
    if (neg_q) begin
      prod_d = m_mag[pbr_pkg::ACC_W-1] ? ACC_MIN : -$signed(m_mag);
    end else begin
      prod_d = m_mag[pbr_pkg::ACC_W-1] ? ACC_MAX : $signed(m_mag);
    end
  end

  // Saturating add of the current coefficient, scaled to Q16.
  always_comb begin
    coef_ext = {{(pbr_pkg::ACC_W-pbr_pkg::COEF_W-pbr_pkg::FRAC_W){coef_i[idx_q][pbr_pkg::COEF_W-1]}},
                coef_i[idx_q], {pbr_pkg::FRAC_W{1'b0}}};
    sum_wide = {prod_q[pbr_pkg::ACC_W-1], prod_q} + {coef_ext[pbr_pkg::ACC_W-1], coef_ext};
    if (sum_wide[pbr_pkg::ACC_W] != sum_wide[pbr_pkg::ACC_W-1]) begin
      acc_d = sum_wide[pbr_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = sum_wide[pbr_pkg::ACC_W-1:0];
    end
  end

  // Leading term and magnitude of x at the start of an evaluation.
  always_comb begin
    lead_ext = {{(pbr_pkg::ACC_W-pbr_pkg::COEF_W-pbr_pkg::FRAC_W)
                 {coef_i[pbr_pkg::MAX_DEGREE][pbr_pkg::COEF_W-1]}},
                coef_i[pbr_pkg::MAX_DEGREE], {pbr_pkg::FRAC_W{1'b0}}};
    x_mag    = req_i.x[pbr_pkg::X_W-1] ? pbr_pkg::X_W'(-req_i.x) : pbr_pkg::X_W'(req_i.x);
  end

  // Step sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      // Done pulses for one cycle after the last coefficient is added.
      done_q <= (state_q == ST_ADD) && (idx_q == '0);
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            acc_q   <= lead_ext;
            xm_q    <= x_mag;
            xneg_q  <= req_i.x[pbr_pkg::X_W-1];
            idx_q   <= pbr_pkg::IDX_W'(pbr_pkg::MAX_DEGREE - 1);
            state_q <= ST_ABS;
          end
        end
        ST_ABS: begin
          am_q    <= acc_q[pbr_pkg::ACC_W-1] ? pbr_pkg::ACC_W'(-acc_q) : pbr_pkg::ACC_W'(acc_q);
          neg_q   <= acc_q[pbr_pkg::ACC_W-1] ^ xneg_q;
          state_q <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          lo_q    <= mul_p;
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          hi_q    <= mul_p;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          acc_q <= acc_d;
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= ST_ABS;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

/* hdl/polynomial_bisection_root.sv */
// ----------------------------------------------------------------------------
// polynomial_bisection_root: fixed-point bisection root finder
// Takes an interval in Q8.16, evaluates the configured polynomial at both
// ends and, unless both share a sign, bisects until |p(mid)| is within tolerance or the step cap is hit.
// ----------------------------------------------------------------------------
// Evaluation: each polynomial evaluation runs six Horner steps on the shared
// 32x24 multiplier. An item evaluates both ends, then one midpoint per
// bisection step, with at most 32 steps.
// Throughput: one item at a time; s_axis_tready is high only while idle, and
// a finished result waits in the output register without blocking input.
// Reset: coefficients clear to zero, tolerance to 66, no result is pending.
// ----------------------------------------------------------------------------
module polynomial_bisection_root (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pbr_pkg::COEF_W-1:0]         cfg_data_i,
  // Request input.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // lower_end[23:0], upper_end[47:24]
  // Result output.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata   // root[23:0], status[25:24],
                                                            // iterations[31:26]
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_A,
    ST_EVAL_B,
    ST_MID,
    ST_EVAL_M,
    ST_FINISH
  } state_e;

  state_e                               state_q;
  pbr_pkg::coef_arr_t                   coef_q;
  logic        [pbr_pkg::TOL_W-1:0]     tol_q;
  logic signed [pbr_pkg::X_W-1:0]       a_q;
  logic signed [pbr_pkg::X_W-1:0]       b_q;
  logic signed [pbr_pkg::X_W-1:0]       mid_q;
  logic                                 fa_pos_q;
  logic                                 fa_neg_q;
  logic        [pbr_pkg::ITER_W-1:0]    iter_q;
  logic signed [pbr_pkg::X_W-1:0]       res_root_q;
  pbr_pkg::status_e                     res_status_q;
  logic                                 out_valid_q;
  logic signed [pbr_pkg::X_W-1:0]       out_root_q;
  pbr_pkg::status_e                     out_status_q;
  logic        [pbr_pkg::ITER_W-1:0]    out_iter_q;

  pbr_pkg::horner_req_t                 h_req;
  pbr_pkg::horner_rsp_t                 h_rsp;
  logic                                 in_req;
  logic signed [pbr_pkg::X_W:0]         mid_sum;
  logic signed [pbr_pkg::X_W-1:0]       mid_d;
  logic signed [pbr_pkg::X_W-1:0]       in_lower;
  logic signed [pbr_pkg::X_W-1:0]       in_upper;
  logic                                 fv_pos;
  logic                                 fv_neg;
  logic signed [pbr_pkg::ACC_W-1:0]     tol_ext;
  logic                                 fv_within;
  logic                                 out_free;

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign in_lower = s_axis_tdata[pbr_pkg::X_W-1:0];
  assign in_upper = s_axis_tdata[2*pbr_pkg::X_W-1:pbr_pkg::X_W];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      tol_q  <= pbr_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pbr_pkg::REG_TOLERANCE) begin
        tol_q <= cfg_data_i;
      end else begin
        coef_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Midpoint, rounded toward minus infinity.
  always_comb begin
    mid_sum = {a_q[pbr_pkg::X_W-1], a_q} + {b_q[pbr_pkg::X_W-1], b_q};
    mid_d   = mid_sum[pbr_pkg::X_W:1];
  end

  // Sign and tolerance tests on the value just evaluated.
  always_comb begin
    fv_pos    = !h_rsp.value[pbr_pkg::ACC_W-1] && (|h_rsp.value);
    fv_neg    = h_rsp.value[pbr_pkg::ACC_W-1];
    tol_ext   = $signed({{(pbr_pkg::ACC_W-pbr_pkg::TOL_W){1'b0}}, tol_q});
    fv_within = (h_rsp.value <= tol_ext) && (h_rsp.value >= -tol_ext);
  end

  // Evaluation requests: first end, second end, then each midpoint.
  always_comb begin
    h_req.start = 1'b0;
    h_req.x     = mid_d;
    case (state_q)
      ST_IDLE: begin
        h_req.start = in_req;
        h_req.x     = in_lower;
      end
      ST_EVAL_A: begin
        h_req.start = h_rsp.done;
        h_req.x     = b_q;
      end
      ST_MID: begin
        h_req.start = 1'b1;
        h_req.x     = mid_d;
      end
      default: begin
        h_req.start = 1'b0;
        h_req.x     = mid_d;
      end
    endcase
  end

  pbr_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_q),
    .req_i  (h_req),
    .rsp_o  (h_rsp)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // Bisection sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result clears unless a new one is loaded in the same cycle.
      if (m_axis_tready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            a_q     <= in_lower;
            b_q     <= in_upper;
            state_q <= ST_EVAL_A;
          end
        end
        ST_EVAL_A: begin
          if (h_rsp.done) begin
            fa_pos_q <= fv_pos;
            fa_neg_q <= fv_neg;
            state_q  <= ST_EVAL_B;
          end
        end
        ST_EVAL_B: begin
          if (h_rsp.done) begin
            iter_q <= '0;
            if ((fa_pos_q && fv_pos) || (fa_neg_q && fv_neg)) begin
              res_root_q   <= '0;
              res_status_q <= pbr_pkg::STAT_NO_SIGN;
              state_q      <= ST_FINISH;
            end else begin
              // Keep the end with the non-positive value in a_q.
              if (fa_pos_q) begin
                a_q <= b_q;
                b_q <= a_q;
              end
              state_q <= ST_MID;
            end
          end
        end
        ST_MID: begin
          mid_q   <= mid_d;
          state_q <= ST_EVAL_M;
        end
        ST_EVAL_M: begin
          if (h_rsp.done) begin
            if (fv_pos) begin
              b_q <= mid_q;
            end else begin
              a_q <= mid_q;
            end
            iter_q     <= iter_q + 1'b1;
            res_root_q <= mid_q;
            if (fv_within) begin
              res_status_q <= pbr_pkg::STAT_CONVERGED;
              state_q      <= ST_FINISH;
            end else if (iter_q == pbr_pkg::ITER_W'(pbr_pkg::MAX_ITER - 1)) begin
              res_status_q <= pbr_pkg::STAT_ITER_CAP;
              state_q      <= ST_FINISH;
            end else begin
              state_q <= ST_MID;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_root_q   <= res_root_q;
            out_status_q <= res_status_q;
            out_iter_q   <= iter_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_iter_q, out_status_q, out_root_q};

endmodule

/* hdl/pbr_checker.sv */
// ----------------------------------------------------------------------------
// pbr_checker: port-level checks for the bisection root finder
// Watches the request and result channels and checks result consistency.
// ----------------------------------------------------------------------------
module pbr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [31:0]                   m_axis_tdata
);

  logic [pbr_pkg::X_W-1:0]    out_root;
  logic [pbr_pkg::STAT_W-1:0] out_status;
  logic [pbr_pkg::ITER_W-1:0] out_iter;

  assign out_root   = m_axis_tdata[23:0];
  assign out_status = m_axis_tdata[25:24];
  assign out_iter   = m_axis_tdata[31:26];

  // One request at a time: after a request is taken the input closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open after a request was taken");

  // A failed sign check reports no steps and a zero root.
  a_no_sign_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status == pbr_pkg::STAT_NO_SIGN) |->
    (out_root == '0 && out_iter == '0))
    else $error("no-sign-change result carries a root or steps");

  // Hitting the cap means exactly the maximum number of steps.
  a_cap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status == pbr_pkg::STAT_ITER_CAP) |->
    (out_iter == pbr_pkg::ITER_W'(pbr_pkg::MAX_ITER)))
    else $error("iteration cap status with wrong step count");

  // Convergence takes at least one step and never more than the cap.
  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status == pbr_pkg::STAT_CONVERGED) |->
    (out_iter != '0 && out_iter <= pbr_pkg::ITER_W'(pbr_pkg::MAX_ITER)))
    else $error("converged result with impossible step count");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind polynomial_bisection_root pbr_checker u_pbr_checker (.*);

/* test/tb_polynomial_bisection_root.sv */
// ----------------------------------------------------------------------------
// tb_polynomial_bisection_root: self-checking bench for the bisection root finder
// A short directed table covers the field extremes, the interval swap, a zero
// at an interval end, a missing sign change, the iteration cap and saturating
// evaluation. Random phases follow: each loads new coefficients and a new
// tolerance, then sends intervals that mostly bracket a sign change. Every
// result is compared field by field against a fixed-point predictor or a table entry.
// ----------------------------------------------------------------------------
module tb_polynomial_bisection_root;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          SETTLE_CYCLES = 1200;
  localparam int          ITEMS_PER_PHASE = 106;
  localparam int          NUM_PHASES = 5;

  // Handy Q8.16 points.
  localparam logic signed [pbr_pkg::X_W-1:0] X_MIN    = 24'sh800000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_MAX    = 24'sh7FFFFF;
  localparam logic signed [pbr_pkg::X_W-1:0] X_ZERO   = 24'sh000000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_NEG1LS = 24'shFFFFFF;
  localparam logic signed [pbr_pkg::X_W-1:0] X_HALF   = 24'sh008000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_ONE    = 24'sh010000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_TWO    = 24'sh020000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_THREE  = 24'sh030000;
  localparam logic signed [pbr_pkg::X_W-1:0] X_NEGONE = 24'shFF0000;

  // Limits of the saturating evaluation accumulator.
  localparam logic signed [127:0] ACC_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] ACC_MIN = -128'sh8000_0000_0000_0000;

  // One result, laid out as on m_axis_tdata.
  typedef struct packed {
    logic [pbr_pkg::ITER_W-1:0]     iters;
    pbr_pkg::status_e               status;
    logic signed [pbr_pkg::X_W-1:0] root;
  } root_result_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SOLVE
  } row_kind_e;

  // One row of the directed table.
  typedef struct packed {
    row_kind_e                      kind;
    pbr_pkg::cfg_reg_e              reg_idx;
    logic [pbr_pkg::COEF_W-1:0]     reg_val;
    logic signed [pbr_pkg::X_W-1:0] lo_end;
    logic signed [pbr_pkg::X_W-1:0] hi_end;
    logic                           known;
    root_result_t                   known_result;
  } plan_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [pbr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pbr_pkg::COEF_W-1:0]    cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [47:0]                   s_axis_tdata = '0;  // lower_end[23:0], upper_end[47:24]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;  // root[23:0], status[25:24], iterations[31:26]

  // Typed expectation that travels with the request on the bus.
  logic                 typed_known = 1'b0;
  root_result_t         typed_result = '0;

  logic                 calm = 1'b0;
  int                   fail_count = 0;
  int unsigned          cycle_count = 0;

  // Mirror of the configuration registers.
  logic signed [pbr_pkg::COEF_W-1:0] coef_copy [pbr_pkg::NUM_COEF];
  logic [pbr_pkg::TOL_W-1:0]         tol_copy;

  root_result_t expected_roots[$];
  plan_row_t    plan[$];

  polynomial_bisection_root i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Clamp to the signed 64-bit range.
  function automatic logic signed [127:0] clamp_acc(logic signed [127:0] v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Horner evaluation in Q47.16; products truncate toward zero, all steps saturate.
  function automatic logic signed [127:0] eval_poly(logic signed [pbr_pkg::X_W-1:0] x);
    logic signed [127:0] acc;
    logic signed [127:0] wide_x;
    logic signed [127:0] prod;
    logic signed [127:0] term;
    acc = coef_copy[pbr_pkg::MAX_DEGREE];
    acc = acc <<< pbr_pkg::FRAC_W;
    wide_x = x;
    for (int i = pbr_pkg::MAX_DEGREE - 1; i >= 0; i--) begin
      prod = acc * wide_x;
      if (prod < 0) begin
        prod = -((-prod) >>> pbr_pkg::FRAC_W);
      end else begin
        prod = prod >>> pbr_pkg::FRAC_W;
      end
      term = coef_copy[i];
      acc = clamp_acc(clamp_acc(prod) + (term <<< pbr_pkg::FRAC_W));
    end
    return acc;
  endfunction

  // Bisect one interval with the current coefficients and tolerance.
  function automatic root_result_t solve_interval(logic signed [pbr_pkg::X_W-1:0] lo_end,
                                                  logic signed [pbr_pkg::X_W-1:0] hi_end);
    root_result_t                   res;
    logic signed [127:0]            f_lo;
    logic signed [127:0]            f_hi;
    logic signed [127:0]            f_mid;
    logic signed [127:0]            mag;
    logic signed [pbr_pkg::X_W-1:0] neg_end;
    logic signed [pbr_pkg::X_W-1:0] pos_end;
    logic signed [pbr_pkg::X_W:0]   sum;
    logic signed [pbr_pkg::X_W-1:0] mid;
    f_lo = eval_poly(lo_end);
    f_hi = eval_poly(hi_end);
    res.root = '0;
    res.status = pbr_pkg::STAT_NO_SIGN;
    res.iters = '0;
    if ((f_lo > 0 && f_hi > 0) || (f_lo < 0 && f_hi < 0)) return res;
    // Keep the end with a positive value on the upper side.
    neg_end = (f_lo > 0) ? hi_end : lo_end;
    pos_end = (f_lo > 0) ? lo_end : hi_end;
    res.status = pbr_pkg::STAT_ITER_CAP;
    for (int step = 1; step <= pbr_pkg::MAX_ITER; step++) begin
      sum = neg_end + pos_end;
      mid = sum[pbr_pkg::X_W:1];
      f_mid = eval_poly(mid);
      if (f_mid > 0) begin
        pos_end = mid;
      end else begin
        neg_end = mid;
      end
      res.root = mid;
      res.iters = pbr_pkg::ITER_W'(step);
      mag = (f_mid < 0) ? -f_mid : f_mid;
      if (mag <= tol_copy) begin
        res.status = pbr_pkg::STAT_CONVERGED;
        break;
      end
    end
    return res;
  endfunction

  function automatic plan_row_t row_write(pbr_pkg::cfg_reg_e idx,
                                          logic [pbr_pkg::COEF_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t row_solve(logic signed [pbr_pkg::X_W-1:0] lo_end,
                                          logic signed [pbr_pkg::X_W-1:0] hi_end);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SOLVE;
    row.lo_end = lo_end;
    row.hi_end = hi_end;
    return row;
  endfunction

  function automatic plan_row_t row_known(logic signed [pbr_pkg::X_W-1:0] lo_end,
                                          logic signed [pbr_pkg::X_W-1:0] hi_end,
                                          logic signed [pbr_pkg::X_W-1:0] root,
                                          pbr_pkg::status_e status,
                                          logic [pbr_pkg::ITER_W-1:0] iters);
    plan_row_t row;
    row = row_solve(lo_end, hi_end);
    row.known = 1'b1;
    row.known_result.root = root;
    row.known_result.status = status;
    row.known_result.iters = iters;
    return row;
  endfunction

  // Interval end: half the time anywhere, half the time within +-4.0.
  function automatic logic signed [pbr_pkg::X_W-1:0] pick_end();
    if ($urandom_range(1) == 1) return pbr_pkg::X_W'($urandom);
    return pbr_pkg::X_W'($urandom_range(524287) - 32'd262144);
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send_interval(logic signed [pbr_pkg::X_W-1:0] lo_end,
                               logic signed [pbr_pkg::X_W-1:0] hi_end,
                               logic known, root_result_t known_result);
    while (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hi_end, lo_end};
    typed_known <= known;
    typed_result <= known_result;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly intervals that bracket a sign change, the rest unfiltered.
  task automatic send_random();
    logic signed [pbr_pkg::X_W-1:0] lo_end;
    logic signed [pbr_pkg::X_W-1:0] hi_end;
    logic signed [127:0]            f_lo;
    logic signed [127:0]            f_hi;
    int                             tries;
    lo_end = pick_end();
    hi_end = pick_end();
    if ($urandom_range(99) < 80) begin
      tries = 0;
      f_lo = eval_poly(lo_end);
      f_hi = eval_poly(hi_end);
      while (tries < 16 && ((f_lo > 0 && f_hi > 0) || (f_lo < 0 && f_hi < 0))) begin
        lo_end = pick_end();
        hi_end = pick_end();
        f_lo = eval_poly(lo_end);
        f_hi = eval_poly(hi_end);
        tries++;
      end
    end
    send_interval(lo_end, hi_end, 1'b0, '0);
  endtask

  // Stop sending and wait until every outstanding result is back.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_roots.size() != 0);
  endtask

  task automatic write_reg(pbr_pkg::cfg_reg_e idx, logic [pbr_pkg::COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure, none during the calm phase.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 23);
  end

  // Register mirror, prediction on each request and result checking.
  always @(posedge clk_i) begin : track
    root_result_t got;
    root_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < pbr_pkg::NUM_COEF; i++) coef_copy[i] = '0;
      tol_copy = pbr_pkg::TOL_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == pbr_pkg::REG_TOLERANCE) begin
          tol_copy = cfg_data_i;
        end else begin
          coef_copy[cfg_index_i] = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (typed_known) begin
          expected_roots.push_back(typed_result);
        end else begin
          expected_roots.push_back(solve_interval(s_axis_tdata[23:0], s_axis_tdata[47:24]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = root_result_t'(m_axis_tdata);
        if (expected_roots.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_roots.pop_front();
          if (got.root !== want.root) begin
            $error("root: expected %0d, got %0d", want.root, got.root);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.iters !== want.iters) begin
            $error("iterations: expected %0d, got %0d", want.iters, got.iters);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int                         degree;
    logic [pbr_pkg::COEF_W-1:0] val;

    // With all coefficients zero every midpoint is an exact root.
    plan.push_back(row_known(X_MIN, X_MAX, X_NEG1LS, pbr_pkg::STAT_CONVERGED, 6'd1));
    plan.push_back(row_known(X_MAX, X_MAX, X_MAX, pbr_pkg::STAT_CONVERGED, 6'd1));
    plan.push_back(row_known(X_MIN, X_MIN, X_MIN, pbr_pkg::STAT_CONVERGED, 6'd1));
    plan.push_back(row_known(X_ZERO, X_ZERO, X_ZERO, pbr_pkg::STAT_CONVERGED, 6'd1));
    // p(x) = x - 1: root hit at once, swapped ends, no sign change, zero at an end.
    plan.push_back(row_write(pbr_pkg::REG_COEF_0, 16'hFFFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_1, 16'h0001));
    plan.push_back(row_known(X_ZERO, X_TWO, X_ONE, pbr_pkg::STAT_CONVERGED, 6'd1));
    plan.push_back(row_known(X_TWO, X_ZERO, X_ONE, pbr_pkg::STAT_CONVERGED, 6'd1));
    plan.push_back(row_known(X_TWO, X_THREE, X_ZERO, pbr_pkg::STAT_NO_SIGN, 6'd0));
    plan.push_back(row_known(X_NEGONE, X_ZERO, X_ZERO, pbr_pkg::STAT_NO_SIGN, 6'd0));
    plan.push_back(row_solve(X_ONE, X_TWO));
    plan.push_back(row_solve(X_MIN, X_MAX));
    // p(x) = 3x - 1 with zero tolerance never converges: iteration cap.
    plan.push_back(row_write(pbr_pkg::REG_COEF_1, 16'h0003));
    plan.push_back(row_write(pbr_pkg::REG_TOLERANCE, 16'h0000));
    plan.push_back(row_solve(X_ZERO, X_ONE));
    plan.push_back(row_solve(X_ONE, X_ZERO));
    // Widest tolerance accepts the first midpoint, p(0.5) = 0.5.
    plan.push_back(row_write(pbr_pkg::REG_TOLERANCE, 16'hFFFF));
    plan.push_back(row_known(X_ZERO, X_ONE, X_HALF, pbr_pkg::STAT_CONVERGED, 6'd1));
    // Extreme coefficients drive the accumulator into saturation.
    plan.push_back(row_write(pbr_pkg::REG_COEF_6, 16'h7FFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_0, 16'h8000));
    plan.push_back(row_write(pbr_pkg::REG_TOLERANCE, pbr_pkg::TOL_RESET));
    plan.push_back(row_solve(X_MIN, X_MAX));
    plan.push_back(row_solve(X_ZERO, X_MAX));
    plan.push_back(row_solve(X_MIN, X_ZERO));
    plan.push_back(row_write(pbr_pkg::REG_COEF_2, 16'h7FFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_3, 16'h7FFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_4, 16'h7FFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_5, 16'h7FFF));
    plan.push_back(row_write(pbr_pkg::REG_COEF_6, 16'h8000));
    plan.push_back(row_solve(X_ZERO, X_MAX));
    plan.push_back(row_solve(X_MIN, X_ZERO));
    plan.push_back(row_solve(X_MAX, X_MIN));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_interval(plan[i].lo_end, plan[i].hi_end, plan[i].known, plan[i].known_result);
      end
    end

    // Random phases, each with a fresh polynomial and tolerance.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_results();
      calm = (phase == 2);
      degree = $urandom_range(pbr_pkg::MAX_DEGREE, 1);
      for (int r = 0; r < pbr_pkg::NUM_COEF; r++) begin
        case (phase)
          0: val = pbr_pkg::COEF_W'($urandom_range(16) - 8);
          2: val = pbr_pkg::COEF_W'($urandom_range(200) - 100);
          3: val = ($urandom_range(1) == 1) ? 16'h8000 : 16'h7FFF;
          default: val = pbr_pkg::COEF_W'($urandom);
        endcase
        if (r > degree) val = '0;
        write_reg(pbr_pkg::cfg_reg_e'(r), val);
      end
      case (phase)
        1: val = 16'h0000;
        2: val = 16'hFFFF;
        4: val = pbr_pkg::TOL_W'($urandom_range(300));
        default: val = pbr_pkg::TOL_W'($urandom);
      endcase
      write_reg(pbr_pkg::REG_TOLERANCE, val);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    wait_results();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pbr_pkg.sv
hdl/pbr_horner.sv
hdl/polynomial_bisection_root.sv
hdl/pbr_checker.sv
test/tb_polynomial_bisection_root.sv
